/* hw/rtl/qsn_pkg.sv */
// Shared constants for the quad surface normal pipeline.
package qsn_pkg;

    localparam int OUT_W       = 16;
    localparam int AXES        = 3;
    localparam int NUM_CORNERS = 4;
    localparam int NUM_TRI     = 4;
    localparam int M_TDATA_W   = AXES * OUT_W;

    // Corner triangles (a, b, c) of the quad; the normal is (b - a) x (c - a).
    localparam int TRI_ORDER [NUM_TRI][3] = '{
        '{0, 1, 3},
        '{1, 2, 0},
        '{2, 3, 1},
        '{3, 0, 2}
    };

endpackage

/* hw/rtl/qsn_norm.sv */
// Pipelined exact scaling of a three-component vector to a rounded unit vector.
module qsn_norm #(
    parameter int IN_W      = 35,
    parameter int FRAC_BITS = 14
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic signed [IN_W-1:0]      in_c [qsn_pkg::AXES],
    output logic                        out_valid,
    output logic signed [FRAC_BITS+1:0] out_q [qsn_pkg::AXES],
    output logic                        out_zero
);

    localparam int SQW = 2 * IN_W;
    localparam int SW  = SQW + 2;
    localparam int WW  = SW + 2 * FRAC_BITS + 6;
    localparam int QW  = FRAC_BITS + 1;
    localparam int NST = FRAC_BITS + 1;

    // Squares of the components.
    logic                   v0_reg;
    logic [SQW-1:0]         sq0_reg  [qsn_pkg::AXES];
    logic                   neg0_reg [qsn_pkg::AXES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_valid;
        end
        if (en) begin
            for (int a = 0; a < qsn_pkg::AXES; a++) begin
                sq0_reg[a]  <= SQW'(in_c[a] * in_c[a]);
                neg0_reg[a] <= in_c[a][IN_W-1];
            end
        end
    end

    // Per step: T = d*d*S and U = d*S with d = 2q - 1, so each trial bit needs only shifts
    // and adds. The trial is kept when d*d*S stays at or below R = 4*c*c*2^(2*FRAC_BITS).
    logic                 v_reg [NST+1];
    logic                 z_reg [NST+1];
    logic signed [WW-1:0] s_reg [NST+1];
    logic signed [WW-1:0] t_reg [NST+1][qsn_pkg::AXES];
    logic signed [WW-1:0] u_reg [NST+1][qsn_pkg::AXES];
    logic signed [WW-1:0] r_reg [NST+1][qsn_pkg::AXES];
    logic [QW-1:0]        q_reg [NST+1][qsn_pkg::AXES];
    logic                 n_reg [NST+1][qsn_pkg::AXES];

    logic [SW-1:0] s_sum;
    assign s_sum = SW'(sq0_reg[0]) + SW'(sq0_reg[1]) + SW'(sq0_reg[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= v0_reg;
        end
        if (en) begin
            s_reg[0] <= WW'(s_sum);
            z_reg[0] <= (s_sum == '0);
            for (int a = 0; a < qsn_pkg::AXES; a++) begin
                t_reg[0][a] <= WW'(s_sum);
                u_reg[0][a] <= -$signed(WW'(s_sum));
                r_reg[0][a] <= WW'(sq0_reg[a]) << (2 * FRAC_BITS + 2);
                q_reg[0][a] <= '0;
                n_reg[0][a] <= neg0_reg[a];
            end
        end
    end

    for (genvar j = 0; j < NST; j++) begin : g_step
        localparam int K = FRAC_BITS - j;
        logic signed [WW-1:0] tc  [qsn_pkg::AXES];
        logic                 acc [qsn_pkg::AXES];

        always_comb begin
            for (int a = 0; a < qsn_pkg::AXES; a++) begin
                tc[a]  = t_reg[j][a] + (u_reg[j][a] <<< (K + 2)) + (s_reg[j] <<< (2 * K + 2));
                acc[a] = (tc[a] <= r_reg[j][a]);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j+1] <= 1'b0;
            end else if (en) begin
                v_reg[j+1] <= v_reg[j];
            end
            if (en) begin
                s_reg[j+1] <= s_reg[j];
                z_reg[j+1] <= z_reg[j];
                for (int a = 0; a < qsn_pkg::AXES; a++) begin
                    r_reg[j+1][a] <= r_reg[j][a];
                    n_reg[j+1][a] <= n_reg[j][a];
                    if (acc[a]) begin
                        t_reg[j+1][a] <= tc[a];
                        u_reg[j+1][a] <= u_reg[j][a] + (s_reg[j] <<< (K + 1));
                        q_reg[j+1][a] <= q_reg[j][a] | (QW'(1) << K);
                    end else begin
                        t_reg[j+1][a] <= t_reg[j][a];
                        u_reg[j+1][a] <= u_reg[j][a];
                        q_reg[j+1][a] <= q_reg[j][a];
                    end
                end
            end
        end
    end

    // Apply the signs; a zero vector gives a zero result.
    logic                        vo_reg;
    logic                        zo_reg;
    logic signed [FRAC_BITS+1:0] qo_reg [qsn_pkg::AXES];
    logic signed [FRAC_BITS+1:0] q_mag  [qsn_pkg::AXES];

    always_comb begin
        for (int a = 0; a < qsn_pkg::AXES; a++) begin
            q_mag[a] = $signed({1'b0, q_reg[NST][a]});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (en) begin
            vo_reg <= v_reg[NST];
        end
        if (en) begin
            zo_reg <= z_reg[NST];
            for (int a = 0; a < qsn_pkg::AXES; a++) begin
                if (z_reg[NST]) begin
                    qo_reg[a] <= '0;
                end else if (n_reg[NST][a]) begin
                    qo_reg[a] <= -q_mag[a];
                end else begin
                    qo_reg[a] <= q_mag[a];
                end
            end
        end
    end

    assign out_valid = vo_reg;
    assign out_zero  = zo_reg;
    assign out_q     = qo_reg;

endmodule

/* hw/rtl/quad_surface_normal.sv */
// Quad face normal: sum of the four unit corner-triangle normals, scaled to unit length.
//
//  channel | ports               | contents
//  --------+---------------------+---------------------------------------------------
//  input   | s_tvalid/tready/... | s_tdata: v1_x..v4_z, COORD_BITS each
//  result  | m_tvalid/tready/... | m_tdata: normal_x, normal_y, normal_z; m_tuser: degenerate
//
// One quad is taken per cycle while the skid register is empty; on its way a result passes
// the two bit-per-stage normalizers of FRAC_BITS + 4 stages each, with the sum register between.
// Reset clears the valid bits of all stages and the output buffers.
// A result that is not taken moves into a skid register; only while that register is full
// does the whole pipeline hold, and nothing is lost or repeated.
module quad_surface_normal #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z, v4_x, v4_y, v4_z
    input  logic [((12*COORD_BITS+7)/8)*8-1:0] s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // normal_x, normal_y, normal_z
    output logic [qsn_pkg::M_TDATA_W-1:0]      m_tdata,
    // degenerate
    output logic                               m_tuser
);

    localparam int EW   = COORD_BITS + 1;
    localparam int PW   = 2 * EW;
    localparam int NW   = PW + 1;
    localparam int QW   = FRAC_BITS + 2;
    localparam int SUMW = FRAC_BITS + 4;
    localparam int OW   = qsn_pkg::OUT_W;

    logic en;
    logic skid_valid_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    logic signed [COORD_BITS-1:0] corner [qsn_pkg::NUM_CORNERS][qsn_pkg::AXES];

    always_comb begin
        for (int i = 0; i < qsn_pkg::NUM_CORNERS; i++) begin
            for (int k = 0; k < qsn_pkg::AXES; k++) begin
                corner[i][k] = s_tdata[(i * qsn_pkg::AXES + k) * COORD_BITS +: COORD_BITS];
            end
        end
    end

    // Edge vectors, products and cross products of the four triangles.
    logic                 v1_reg, v2_reg, v3_reg;
    logic signed [EW-1:0] e_reg [qsn_pkg::NUM_TRI][qsn_pkg::AXES];
    logic signed [EW-1:0] f_reg [qsn_pkg::NUM_TRI][qsn_pkg::AXES];
    logic signed [PW-1:0] p_reg [qsn_pkg::NUM_TRI][6];
    logic signed [NW-1:0] n_reg [qsn_pkg::NUM_TRI][qsn_pkg::AXES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
        if (en) begin
            for (int t = 0; t < qsn_pkg::NUM_TRI; t++) begin
                for (int k = 0; k < qsn_pkg::AXES; k++) begin
                    e_reg[t][k] <= EW'(corner[qsn_pkg::TRI_ORDER[t][1]][k])
                                 - EW'(corner[qsn_pkg::TRI_ORDER[t][0]][k]);
                    f_reg[t][k] <= EW'(corner[qsn_pkg::TRI_ORDER[t][2]][k])
                                 - EW'(corner[qsn_pkg::TRI_ORDER[t][0]][k]);
                end
                p_reg[t][0] <= e_reg[t][1] * f_reg[t][2];
                p_reg[t][1] <= e_reg[t][2] * f_reg[t][1];
                p_reg[t][2] <= e_reg[t][2] * f_reg[t][0];
                p_reg[t][3] <= e_reg[t][0] * f_reg[t][2];
                p_reg[t][4] <= e_reg[t][0] * f_reg[t][1];
                p_reg[t][5] <= e_reg[t][1] * f_reg[t][0];
                n_reg[t][0] <= NW'(p_reg[t][0]) - NW'(p_reg[t][1]);
                n_reg[t][1] <= NW'(p_reg[t][2]) - NW'(p_reg[t][3]);
                n_reg[t][2] <= NW'(p_reg[t][4]) - NW'(p_reg[t][5]);
            end
        end
    end

    logic signed [QW-1:0] tq [qsn_pkg::NUM_TRI][qsn_pkg::AXES];
    logic                 tri_valid;

    qsn_norm #(.IN_W(NW), .FRAC_BITS(FRAC_BITS)) u_norm_tri0 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v3_reg), .in_c(n_reg[0]),
        .out_valid(tri_valid), .out_q(tq[0]), .out_zero()
    );
    qsn_norm #(.IN_W(NW), .FRAC_BITS(FRAC_BITS)) u_norm_tri1 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v3_reg), .in_c(n_reg[1]),
        .out_valid(), .out_q(tq[1]), .out_zero()
    );
    qsn_norm #(.IN_W(NW), .FRAC_BITS(FRAC_BITS)) u_norm_tri2 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v3_reg), .in_c(n_reg[2]),
        .out_valid(), .out_q(tq[2]), .out_zero()
    );
    qsn_norm #(.IN_W(NW), .FRAC_BITS(FRAC_BITS)) u_norm_tri3 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v3_reg), .in_c(n_reg[3]),
        .out_valid(), .out_q(tq[3]), .out_zero()
    );

    logic                   vs_reg;
    logic signed [SUMW-1:0] sum_reg [qsn_pkg::AXES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vs_reg <= 1'b0;
        end else if (en) begin
            vs_reg <= tri_valid;
        end
        if (en) begin
            for (int k = 0; k < qsn_pkg::AXES; k++) begin
                sum_reg[k] <= SUMW'(tq[0][k]) + SUMW'(tq[1][k])
                            + SUMW'(tq[2][k]) + SUMW'(tq[3][k]);
            end
        end
    end

    logic signed [QW-1:0] fq [qsn_pkg::AXES];
    logic                 f_valid;
    logic                 f_zero;

    qsn_norm #(.IN_W(SUMW), .FRAC_BITS(FRAC_BITS)) u_norm_sum (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(vs_reg), .in_c(sum_reg),
        .out_valid(f_valid), .out_q(fq), .out_zero(f_zero)
    );

    logic [qsn_pkg::M_TDATA_W-1:0] new_data;
    assign new_data = {OW'(fq[2]), OW'(fq[1]), OW'(fq[0])};

    // Output register with a skid register behind it.
    logic                          m_valid_reg;
    logic [qsn_pkg::M_TDATA_W-1:0] m_data_reg;
    logic                          m_user_reg;
    logic [qsn_pkg::M_TDATA_W-1:0] skid_data_reg;
    logic                          skid_user_reg;
    logic                          push;
    logic                          pop;

    assign push = en && f_valid;
    assign pop  = m_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                m_data_reg     <= skid_data_reg;
                m_user_reg     <= skid_user_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!m_valid_reg || pop) begin
                m_data_reg  <= new_data;
                m_user_reg  <= f_zero;
                m_valid_reg <= 1'b1;
            end else begin
                skid_data_reg  <= new_data;
                skid_user_reg  <= f_zero;
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

/* sim/tb.sv */
// Testbench for quad_surface_normal: directed quads, then random ones, checked against a predictor.
module tb;

    localparam int CB      = 16;
    localparam int FB      = 14;
    localparam int S_W     = ((12 * CB + 7) / 8) * 8;
    localparam int LATENCY = 2 * FB + 13;
    localparam int N_RAND  = 800;
    localparam int OW      = qsn_pkg::OUT_W;

    typedef logic signed [CB-1:0] coord_t;
    typedef coord_t quad_t [12];

    typedef struct packed {
        logic signed [OW-1:0] nx;
        logic signed [OW-1:0] ny;
        logic signed [OW-1:0] nz;
        logic                 degen;
    } normal_t;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [S_W-1:0]   s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [qsn_pkg::M_TDATA_W-1:0] m_tdata;
    logic             m_tuser;

    normal_t normal_fifo[$];
    int      errors;
    bit      calm;

    quad_surface_normal #(.COORD_BITS(CB), .FRAC_BITS(FB)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Exact unit scaling; magnitudes fit comfortably in 200-bit arithmetic.
    function automatic bit unit_scale(input longint c [3], output longint q [3]);
        logic [199:0] s, m2, rhs, d;
        longint       lo, hi, mid, mg;
        s = '0;
        for (int i = 0; i < 3; i++) begin
            mg = (c[i] < 0) ? -c[i] : c[i];
            s += 200'(mg) * 200'(mg);
        end
        if (s == 0) begin
            q = '{0, 0, 0};
            return 1'b0;
        end
        for (int i = 0; i < 3; i++) begin
            mg = (c[i] < 0) ? -c[i] : c[i];
            m2 = 200'(mg) * 200'(mg);
            rhs = m2 << (2 * FB + 2);
            lo = 0;
            hi = longint'(1) << FB;
            while (lo < hi) begin
                mid = (lo + hi + 1) >>> 1;
                d = 200'(2 * mid - 1);
                if (d * d * s <= rhs) lo = mid;
                else hi = mid - 1;
            end
            q[i] = (c[i] < 0) ? -lo : lo;
        end
        return 1'b1;
    endfunction

    function automatic normal_t predict_normal(input quad_t v);
        longint  p [4][3];
        longint  e [3], f [3], n [3], t [3], sum [3], r [3];
        int      a, b, c;
        bit      ok;
        normal_t res;
        sum = '{0, 0, 0};
        for (int i = 0; i < 4; i++)
            for (int k = 0; k < 3; k++) p[i][k] = longint'(v[i*3+k]);
        for (int i = 0; i < qsn_pkg::NUM_TRI; i++) begin
            a = qsn_pkg::TRI_ORDER[i][0];
            b = qsn_pkg::TRI_ORDER[i][1];
            c = qsn_pkg::TRI_ORDER[i][2];
            for (int k = 0; k < 3; k++) begin
                e[k] = p[b][k] - p[a][k];
                f[k] = p[c][k] - p[a][k];
            end
            n[0] = e[1] * f[2] - e[2] * f[1];
            n[1] = e[2] * f[0] - e[0] * f[2];
            n[2] = e[0] * f[1] - e[1] * f[0];
            void'(unit_scale(n, t));
            for (int k = 0; k < 3; k++) sum[k] += t[k];
        end
        ok = unit_scale(sum, r);
        res.nx = OW'(r[0]);
        res.ny = OW'(r[1]);
        res.nz = OW'(r[2]);
        res.degen = !ok;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // Sends one quad; waits for its transfer.
    task automatic send_quad(input quad_t v);
        logic [S_W-1:0] d;
        d = '0;
        for (int i = 0; i < 12; i++) d[i*CB +: CB] = v[i];
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        normal_fifo.push_back(predict_normal(v));
    endtask

    // Result side: random stalls, compare against the oldest expectation.
    initial begin
        normal_t want;
        m_tready = 1'b0;
        @(posedge aclk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (normal_fifo.size() == 0) begin
                    report_mismatch("result transfer with nothing expected", 1, 0);
                end else begin
                    want = normal_fifo.pop_front();
                    if ($signed(m_tdata[0 +: OW]) != want.nx)
                        report_mismatch("normal_x", $signed(m_tdata[0 +: OW]), want.nx);
                    if ($signed(m_tdata[OW +: OW]) != want.ny)
                        report_mismatch("normal_y", $signed(m_tdata[OW +: OW]), want.ny);
                    if ($signed(m_tdata[2*OW +: OW]) != want.nz)
                        report_mismatch("normal_z", $signed(m_tdata[2*OW +: OW]), want.nz);
                    if (m_tuser != want.degen)
                        report_mismatch("degenerate", m_tuser, want.degen);
                end
            end
        end
    end

    initial begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic quad_t rand_quad(input int span);
        quad_t v;
        for (int i = 0; i < 12; i++)
            v[i] = coord_t'($urandom_range(0, 2 * span) - span);
        return v;
    endfunction

    initial begin
        // Directed quads; a row with a typed result is checked against it as well.
        quad_t   dir_quads [12];
        bit      dir_known [12];
        normal_t dir_want  [12];
        quad_t   v;
        normal_t p;
        int      n, mode;
        errors = 0;
        calm = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        // Unit square in the xy plane, counter-clockwise: normal +z.
        dir_quads[0] = '{0,0,0, 1,0,0, 1,1,0, 0,1,0};
        dir_known[0] = 1; dir_want[0] = '{0, 0, 16384, 1'b0};
        // Same square, clockwise: normal -z.
        dir_quads[1] = '{0,0,0, 0,1,0, 1,1,0, 1,0,0};
        dir_known[1] = 1; dir_want[1] = '{0, 0, -16384, 1'b0};
        // Square in yz plane: normal +x.
        dir_quads[2] = '{0,0,0, 0,1,0, 0,1,1, 0,0,1};
        dir_known[2] = 1; dir_want[2] = '{16384, 0, 0, 1'b0};
        // Square in zx plane: normal +y.
        dir_quads[3] = '{0,0,0, 0,0,1, 1,0,1, 1,0,0};
        dir_known[3] = 1; dir_want[3] = '{0, 16384, 0, 1'b0};
        // All corners equal: every triangle degenerate, zero sum.
        dir_quads[4] = '{5,-7,9, 5,-7,9, 5,-7,9, 5,-7,9};
        dir_known[4] = 1; dir_want[4] = '{0, 0, 0, 1'b1};
        // Collinear corners: zero sum.
        dir_quads[5] = '{0,0,0, 1,1,1, 2,2,2, 3,3,3};
        dir_known[5] = 1; dir_want[5] = '{0, 0, 0, 1'b1};
        // Extreme coordinates square: full-range differences.
        dir_quads[6] = '{-32768,-32768,0, 32767,-32768,0, 32767,32767,0, -32768,32767,0};
        dir_known[6] = 1; dir_want[6] = '{0, 0, 16384, 1'b0};
        // Bow-tie: two corner normals point up and two down, so they cancel out.
        dir_quads[7] = '{0,0,0, 1,0,0, 0,1,0, 1,1,0};
        dir_known[7] = 0;
        // Twisted quads at the extremes, checked by the predictor.
        dir_quads[8] = '{-32768,32767,-32768, 32767,-32768,32767, -32768,-32768,32767,
                         32767,32767,-32768};
        dir_known[8] = 0;
        dir_quads[9] = '{32767,0,-32768, 0,32767,0, -32768,0,32767, 0,-32768,1};
        dir_known[9] = 0;
        // Triangle with a repeated corner: two corner triangles degenerate.
        dir_quads[10] = '{0,0,0, 10,0,0, 10,0,0, 0,10,3};
        dir_known[10] = 0;
        dir_quads[11] = '{-1,-1,-1, -1,-1,-1, 32767,-32768,-1, -32768,32767,-1};
        dir_known[11] = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int i = 0; i < 12; i++) begin
            if (dir_known[i]) begin
                p = predict_normal(dir_quads[i]);
                if (p != dir_want[i]) begin
                    $display("directed row %0d: table and predictor disagree", i);
                    errors++;
                end
            end
            send_quad(dir_quads[i]);
        end
        // Hold off until the pipeline has drained completely.
        s_tvalid <= 1'b0;
        while (normal_fifo.size() != 0) @(posedge aclk);
        for (n = 0; n < N_RAND; n++) begin
            if (n > N_RAND - 100) calm = 1'b1;
            mode = $urandom_range(0, 9);
            if (mode < 5) v = rand_quad(32768);
            else if (mode < 8) v = rand_quad($urandom_range(1, 8));
            else begin
                // Planar quad of small coordinates whose last corner repeats the first, near-degenerate at times.
                v = rand_quad(3);
                for (int k = 0; k < 3; k++) v[9+k] = v[k];
            end
            send_quad(v);
        end
        s_tvalid <= 1'b0;
        while (normal_fifo.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        if (errors == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end
endmodule
